@@ design/qrm_pkg.sv @@
// Shared types, constants and rounding helpers for the quaternion-to-matrix pipeline.
package qrm_pkg;

    localparam int FRAC_BITS_DEF    = 14;
    localparam int NEWTON_STEPS_DEF = 3;

    localparam int NORM_STAGES   = 4;
    localparam int NEWTON_STAGES = 3;
    localparam int MAT_STAGES    = 5;

    typedef struct packed {
        logic signed [15:0] q_w;
        logic signed [15:0] q_x;
        logic signed [15:0] q_y;
        logic signed [15:0] q_z;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] m_00;
        logic signed [15:0] m_01;
        logic signed [15:0] m_02;
        logic signed [15:0] m_10;
        logic signed [15:0] m_11;
        logic signed [15:0] m_12;
        logic signed [15:0] m_20;
        logic signed [15:0] m_21;
        logic signed [15:0] m_22;
        logic               zero_input;
    } rot_t;

    // per-request data that rides alongside the reciprocal square root
    typedef struct packed {
        quat_t      q;
        logic [4:0] sh;
        logic       zero;
    } side_t;

    // shift right, rounding half away from zero; sh in 1..62
    function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                     input logic [5:0] sh);
        logic [63:0] mag;
        logic [63:0] half;
        logic [63:0] r;
        mag  = v[63] ? 64'(-v) : 64'(v);
        half = 64'd1 << (sh - 6'd1);
        r    = (mag + half) >> sh;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [15:0] to_entry(input logic signed [63:0] v, input int frac);
        logic signed [63:0] r;
        logic signed [63:0] one;
        one = 64'sd1 <<< frac;
        r   = shr_round(v, 6'(60 - frac));
        if (r > one)
            r = one;
        if (r < -one)
            r = -one;
        if (r > 64'sd32767)
            r = 64'sd32767;
        if (r < -64'sd32768)
            r = -64'sd32768;
        return r[15:0];
    endfunction

endpackage

@@ design/qrm_norm.sv @@
// Squared magnitude, even normalizing shift and Newton seed.
module qrm_norm (
    input  logic          clk,
    input  logic          en,
    input  qrm_pkg::quat_t q_in,
    output logic [31:0]   t_out,
    output logic [31:0]   y_out,
    output qrm_pkg::side_t side_out
);
    import qrm_pkg::*;

    // stage 1: squares
    quat_t       q1_reg;
    logic [30:0] sq_reg [4];
    logic signed [31:0] sq_next [4];

    // stage 2: sum
    quat_t       q2_reg;
    logic [32:0] s2_reg;

    // stage 3: shift search
    quat_t       q3_reg;
    logic [32:0] s3_reg;
    logic [3:0]  k_reg;
    logic [3:0]  k_next;
    logic        zero3_reg;

    // stage 4: apply shift, seed
    logic [31:0] t_reg;
    logic [31:0] y_reg;
    side_t       side_reg;
    logic [31:0] t_next;

    always_comb
    begin
        sq_next[0] = q_in.q_w * q_in.q_w;
        sq_next[1] = q_in.q_x * q_in.q_x;
        sq_next[2] = q_in.q_y * q_in.q_y;
        sq_next[3] = q_in.q_z * q_in.q_z;
    end

    always_comb
    begin
        k_next = 4'd15;
        for (int j = 15; j >= 0; j--)
        begin
            if (|s2_reg[31 - 2 * j -: 2])
                k_next = 4'(j);
        end
    end

    always_comb
    begin
        if (s3_reg[32])
            t_next = {1'b0, s3_reg[32:2]};
        else
            t_next = s3_reg[31:0] << {k_reg, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg <= q_in;
            for (int i = 0; i < 4; i++)
                sq_reg[i] <= sq_next[i][30:0];

            q2_reg <= q1_reg;
            s2_reg <= 33'(sq_reg[0]) + 33'(sq_reg[1]) + 33'(sq_reg[2]) + 33'(sq_reg[3]);

            q3_reg    <= q2_reg;
            s3_reg    <= s2_reg;
            k_reg     <= k_next;
            zero3_reg <= (s2_reg == 33'd0);

            t_reg         <= t_next;
            y_reg         <= 32'h8000_0000 - (t_next >> 2);
            side_reg.q    <= q3_reg;
            side_reg.sh   <= s3_reg[32] ? 5'd17 : 5'd16 - 5'(k_reg);
            side_reg.zero <= zero3_reg;
        end
    end

    assign t_out    = t_reg;
    assign y_out    = y_reg;
    assign side_out = side_reg;

endmodule

@@ design/qrm_newton.sv @@
// One Newton step of the reciprocal square root, three multiply stages.
module qrm_newton (
    input  logic           clk,
    input  logic           en,
    input  logic [31:0]    t_in,
    input  logic [31:0]    y_in,
    input  qrm_pkg::side_t side_in,
    output logic [31:0]    t_out,
    output logic [31:0]    y_out,
    output qrm_pkg::side_t side_out
);
    import qrm_pkg::*;

    localparam logic [33:0] THREE_Q30 = 34'd3 << 30;

    logic [31:0] t1_reg, y1_reg, y2_reg;
    side_t       sd1_reg;
    logic [63:0] yy_next;

    logic [31:0] t2_reg, y2b_reg, f_reg;
    side_t       sd2_reg;
    logic [63:0] ty_next;
    logic [33:0] p_next;

    logic [31:0] t3_reg, y3_reg;
    side_t       sd3_reg;
    logic [63:0] yf_next;
    logic [32:0] yn_next;

    assign yy_next = 64'(y_in) * 64'(y_in);
    assign ty_next = 64'(t1_reg) * 64'(y2_reg);
    assign p_next  = ty_next[63:30];
    assign yf_next = 64'(y2b_reg) * 64'(f_reg);
    assign yn_next = yf_next[63:31];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg  <= t_in;
            y1_reg  <= y_in;
            y2_reg  <= yy_next[63:32];
            sd1_reg <= side_in;

            t2_reg  <= t1_reg;
            y2b_reg <= y1_reg;
            f_reg   <= (p_next >= THREE_Q30) ? 32'd0 : 32'(THREE_Q30 - p_next);
            sd2_reg <= sd1_reg;

            t3_reg  <= t2_reg;
            y3_reg  <= (yn_next > 33'h0_8000_0000) ? 32'h8000_0000 : yn_next[31:0];
            sd3_reg <= sd2_reg;
        end
    end

    assign t_out    = t3_reg;
    assign y_out    = y3_reg;
    assign side_out = sd3_reg;

endmodule

@@ design/qrm_matrix.sv @@
// Unit components, pairwise products and rounded, clamped matrix entries.
module qrm_matrix #(
    parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           en,
    input  logic [31:0]    y_in,
    input  qrm_pkg::side_t side_in,
    output qrm_pkg::rot_t  m_out
);
    import qrm_pkg::*;

    localparam logic signed [63:0] Q30_ONE = 64'sd1 <<< 30;
    localparam logic signed [63:0] ONE60   = 64'sd1 <<< 60;
    localparam logic [15:0]        DIAG_ONE = to_entry(64'sd1 <<< 60, FRAC_BITS);

    logic signed [48:0] pu_reg [4];
    logic [4:0]         sh1_reg;
    logic               z1_reg;
    logic signed [32:0] ye;

    logic signed [31:0] u_reg [4];
    logic signed [63:0] u_next [4];
    logic               z2_reg;

    logic signed [63:0] pxx_reg, pyy_reg, pzz_reg, pxy_reg, pxz_reg, pyz_reg;
    logic signed [63:0] pwx_reg, pwy_reg, pwz_reg;
    logic               z3_reg;

    logic signed [63:0] a_reg [9];
    logic               z4_reg;

    rot_t               out_reg;
    rot_t               out_next;

    assign ye = $signed({1'b0, y_in});

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            u_next[i] = shr_round(64'(pu_reg[i]), {1'b0, sh1_reg});
            if (u_next[i] > Q30_ONE)
                u_next[i] = Q30_ONE;
            if (u_next[i] < -Q30_ONE)
                u_next[i] = -Q30_ONE;
        end
    end

    always_comb
    begin
        if (z4_reg)
        begin
            out_next      = '0;
            out_next.m_00 = DIAG_ONE;
            out_next.m_11 = DIAG_ONE;
            out_next.m_22 = DIAG_ONE;
            out_next.zero_input = 1'b1;
        end
        else
        begin
            out_next.m_00 = to_entry(a_reg[0], FRAC_BITS);
            out_next.m_01 = to_entry(a_reg[1], FRAC_BITS);
            out_next.m_02 = to_entry(a_reg[2], FRAC_BITS);
            out_next.m_10 = to_entry(a_reg[3], FRAC_BITS);
            out_next.m_11 = to_entry(a_reg[4], FRAC_BITS);
            out_next.m_12 = to_entry(a_reg[5], FRAC_BITS);
            out_next.m_20 = to_entry(a_reg[6], FRAC_BITS);
            out_next.m_21 = to_entry(a_reg[7], FRAC_BITS);
            out_next.m_22 = to_entry(a_reg[8], FRAC_BITS);
            out_next.zero_input = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pu_reg[0] <= side_in.q.q_w * ye;
            pu_reg[1] <= side_in.q.q_x * ye;
            pu_reg[2] <= side_in.q.q_y * ye;
            pu_reg[3] <= side_in.q.q_z * ye;
            sh1_reg   <= side_in.sh;
            z1_reg    <= side_in.zero;

            for (int i = 0; i < 4; i++)
                u_reg[i] <= u_next[i][31:0];
            z2_reg <= z1_reg;

            // index order w, x, y, z
            pxx_reg <= 64'(u_reg[1]) * 64'(u_reg[1]);
            pyy_reg <= 64'(u_reg[2]) * 64'(u_reg[2]);
            pzz_reg <= 64'(u_reg[3]) * 64'(u_reg[3]);
            pxy_reg <= 64'(u_reg[1]) * 64'(u_reg[2]);
            pxz_reg <= 64'(u_reg[1]) * 64'(u_reg[3]);
            pyz_reg <= 64'(u_reg[2]) * 64'(u_reg[3]);
            pwx_reg <= 64'(u_reg[0]) * 64'(u_reg[1]);
            pwy_reg <= 64'(u_reg[0]) * 64'(u_reg[2]);
            pwz_reg <= 64'(u_reg[0]) * 64'(u_reg[3]);
            z3_reg  <= z2_reg;

            a_reg[0] <= ONE60 - ((pyy_reg + pzz_reg) <<< 1);
            a_reg[1] <= (pxy_reg - pwz_reg) <<< 1;
            a_reg[2] <= (pxz_reg + pwy_reg) <<< 1;
            a_reg[3] <= (pxy_reg + pwz_reg) <<< 1;
            a_reg[4] <= ONE60 - ((pxx_reg + pzz_reg) <<< 1);
            a_reg[5] <= (pyz_reg - pwx_reg) <<< 1;
            a_reg[6] <= (pxz_reg - pwy_reg) <<< 1;
            a_reg[7] <= (pyz_reg + pwx_reg) <<< 1;
            a_reg[8] <= ONE60 - ((pxx_reg + pyy_reg) <<< 1);
            z4_reg   <= z3_reg;

            out_reg <= out_next;
        end
    end

    assign m_out = out_reg;

endmodule

@@ design/quaternion_to_rotation_matrix.sv @@
// Throughput: one request per cycle; the whole pipeline holds while the
// output register is full and out_ready is low.
// Reset (rst_n, async, active low) clears all valid bits; data registers are not reset.
// Each Newton step is three multiply stages.
module quaternion_to_rotation_matrix #(
    parameter int FRAC_BITS    = qrm_pkg::FRAC_BITS_DEF,
    parameter int NEWTON_STEPS = qrm_pkg::NEWTON_STEPS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  qrm_pkg::quat_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output qrm_pkg::rot_t  out_data
);
    import qrm_pkg::*;

    localparam int LAT = NORM_STAGES + NEWTON_STAGES * NEWTON_STEPS + MAT_STAGES;

    logic [LAT-1:0] vld_reg;
    logic           en;

    logic [31:0] t_s    [NEWTON_STEPS+1];
    logic [31:0] y_s    [NEWTON_STEPS+1];
    side_t       side_s [NEWTON_STEPS+1];

    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    qrm_norm u_norm (
        .clk      (clk),
        .en       (en),
        .q_in     (in_data),
        .t_out    (t_s[0]),
        .y_out    (y_s[0]),
        .side_out (side_s[0])
    );

    for (genvar g = 0; g < NEWTON_STEPS; g++)
    begin : g_newton
        qrm_newton u_newton (
            .clk      (clk),
            .en       (en),
            .t_in     (t_s[g]),
            .y_in     (y_s[g]),
            .side_in  (side_s[g]),
            .t_out    (t_s[g+1]),
            .y_out    (y_s[g+1]),
            .side_out (side_s[g+1])
        );
    end

    qrm_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .clk     (clk),
        .en      (en),
        .y_in    (y_s[NEWTON_STEPS]),
        .side_in (side_s[NEWTON_STEPS]),
        .m_out   (out_data)
    );

endmodule

@@ design/qrm_checker.sv @@
// Port-level checks for the quaternion-to-matrix pipeline, bound to the top level.
module qrm_checker #(
    parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEF
) (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input qrm_pkg::quat_t in_data,
    input logic           out_valid,
    input logic           out_ready,
    input qrm_pkg::rot_t  out_data
);
    import qrm_pkg::*;

    localparam logic signed [17:0] LIM_HI = (FRAC_BITS >= 15) ? 18'sd32767 :
                                            18'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [17:0] LIM_LO = (FRAC_BITS >= 15) ? -18'sd32768 : -LIM_HI;

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("request changed while waiting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_zero_ident: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_input |->
            out_data.m_01 == 16'sd0 && out_data.m_02 == 16'sd0 &&
            out_data.m_10 == 16'sd0 && out_data.m_12 == 16'sd0 &&
            out_data.m_20 == 16'sd0 && out_data.m_21 == 16'sd0 &&
            out_data.m_00 == out_data.m_11 && out_data.m_11 == out_data.m_22)
        else $error("zero request did not give identity");

    a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            18'(out_data.m_00) <= LIM_HI && 18'(out_data.m_00) >= LIM_LO &&
            18'(out_data.m_11) <= LIM_HI && 18'(out_data.m_11) >= LIM_LO &&
            18'(out_data.m_22) <= LIM_HI && 18'(out_data.m_22) >= LIM_LO)
        else $error("diagonal entry beyond one");

endmodule

bind quaternion_to_rotation_matrix qrm_checker #(.FRAC_BITS(FRAC_BITS)) u_qrm_checker (.*);

@@ sim/tb_quaternion_to_rotation_matrix.sv @@
// Testbench for quaternion_to_rotation_matrix: directed and random requests vs. a local predictor.
module tb_quaternion_to_rotation_matrix;
    timeunit 1ns;
    timeprecision 1ps;

    import qrm_pkg::*;

    localparam int FRAC     = 14;
    localparam int STEPS    = 3;
    localparam int LATENCY  = 4 + 3 * STEPS + 5;
    localparam int MAX_CYC  = 400000;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    quat_t in_data;
    logic  out_valid;
    logic  out_ready;
    rot_t  out_data;

    rot_t  pending_mats[$];
    int    err_cnt;
    int    sent_cnt;
    int    recv_cnt;
    int    zero_cnt;
    int    cyc;
    int    send_idle_pct;
    int    recv_idle_pct;

    quaternion_to_rotation_matrix #(.FRAC_BITS(FRAC), .NEWTON_STEPS(STEPS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint rnd_shr(longint v, int sh);
        longint h;
        h = longint'(1) << (sh - 1);
        if (v >= 0)
            return (v + h) >>> sh;
        return -((-v + h) >>> sh);
    endfunction

    function automatic logic [15:0] entry_of(longint v);
        longint r;
        longint one;
        one = longint'(1) << FRAC;
        r = rnd_shr(v, 60 - FRAC);
        if (r > one) r = one;
        if (r < -one) r = -one;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic rot_t rotation_of(quat_t q);
        rot_t m;
        longint qq[4];
        longint u[4];
        longint w, x, y, z, one60, f, p;
        logic [63:0] sum, t, yy, y2;
        int s;
        qq[0] = q.q_w; qq[1] = q.q_x; qq[2] = q.q_y; qq[3] = q.q_z;
        sum = 0;
        for (int i = 0; i < 4; i++) sum += 64'(qq[i] * qq[i]);
        one60 = longint'(1) << 60;
        if (sum == 0)
        begin
            m = '0;
            m.m_00 = entry_of(one60);
            m.m_11 = entry_of(one60);
            m.m_22 = entry_of(one60);
            m.zero_input = 1'b1;
            return m;
        end
        t = sum;
        s = 0;
        while (t >= (64'd1 << 32)) begin t = t >> 2; s -= 2; end
        while (t < (64'd1 << 30)) begin t = t << 2; s += 2; end
        yy = (64'd1 << 31) - (t >> 2);
        for (int i = 0; i < STEPS; i++)
        begin
            y2 = (yy * yy) >> 32;
            p = longint'((t * y2) >> 30);
            f = 3 * (longint'(1) << 30) - p;
            if (f < 0) f = 0;
            yy = (yy * 64'(f)) >> 31;
            if (yy > (64'd1 << 31)) yy = 64'd1 << 31;
        end
        for (int i = 0; i < 4; i++)
        begin
            u[i] = rnd_shr(qq[i] * longint'(yy), 16 - s / 2);
            if (u[i] > (longint'(1) << 30)) u[i] = longint'(1) << 30;
            if (u[i] < -(longint'(1) << 30)) u[i] = -(longint'(1) << 30);
        end
        w = u[0]; x = u[1]; y = u[2]; z = u[3];
        m.m_00 = entry_of(one60 - 2 * (y * y + z * z));
        m.m_01 = entry_of(2 * (x * y - w * z));
        m.m_02 = entry_of(2 * (x * z + w * y));
        m.m_10 = entry_of(2 * (x * y + w * z));
        m.m_11 = entry_of(one60 - 2 * (x * x + z * z));
        m.m_12 = entry_of(2 * (y * z - w * x));
        m.m_20 = entry_of(2 * (x * z - w * y));
        m.m_21 = entry_of(2 * (y * z + w * x));
        m.m_22 = entry_of(one60 - 2 * (x * x + y * y));
        m.zero_input = 1'b0;
        return m;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH result %0d %s: got %0d expected %0d", recv_cnt, what, got, want);
        err_cnt++;
    endtask

    // one request; valid stays up into the next request unless the sender idles
    task automatic send_quat(quat_t q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= q;
        pending_mats.push_back(rotation_of(q));
        do @(posedge clk); while (!in_ready);
        sent_cnt++;
    endtask

    task automatic send_wxyz(int w, int x, int y, int z);
        quat_t q;
        q.q_w = 16'(w); q.q_x = 16'(x); q.q_y = 16'(y); q.q_z = 16'(z);
        send_quat(q);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_mats.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_mats.size() == 0)
            begin
                $display("UNEXPECTED result %0d", recv_cnt);
                err_cnt++;
            end
            else
            begin
                rot_t e;
                e = pending_mats.pop_front();
                if (out_data.m_00 !== e.m_00) report_mismatch("m_00", out_data.m_00, e.m_00);
                if (out_data.m_01 !== e.m_01) report_mismatch("m_01", out_data.m_01, e.m_01);
                if (out_data.m_02 !== e.m_02) report_mismatch("m_02", out_data.m_02, e.m_02);
                if (out_data.m_10 !== e.m_10) report_mismatch("m_10", out_data.m_10, e.m_10);
                if (out_data.m_11 !== e.m_11) report_mismatch("m_11", out_data.m_11, e.m_11);
                if (out_data.m_12 !== e.m_12) report_mismatch("m_12", out_data.m_12, e.m_12);
                if (out_data.m_20 !== e.m_20) report_mismatch("m_20", out_data.m_20, e.m_20);
                if (out_data.m_21 !== e.m_21) report_mismatch("m_21", out_data.m_21, e.m_21);
                if (out_data.m_22 !== e.m_22) report_mismatch("m_22", out_data.m_22, e.m_22);
                if (out_data.zero_input !== e.zero_input)
                    report_mismatch("zero_input", out_data.zero_input, e.zero_input);
                if (e.zero_input) zero_cnt++;
            end
            recv_cnt++;
        end
    end

    always @(posedge clk)
    begin
        if (cyc >= MAX_CYC)
        begin
            $display("TIMEOUT after %0d cycles", cyc);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_directed();
        send_wxyz(0, 0, 0, 0);
        send_wxyz(16384, 0, 0, 0);
        send_wxyz(-16384, 0, 0, 0);
        send_wxyz(0, 16384, 0, 0);
        send_wxyz(0, 0, 16384, 0);
        send_wxyz(0, 0, 0, 16384);
        send_wxyz(32767, 32767, 32767, 32767);
        send_wxyz(-32768, -32768, -32768, -32768);
        send_wxyz(-32768, 0, 0, 0);
        send_wxyz(32767, 0, 0, 0);
        send_wxyz(1, 0, 0, 0);
        send_wxyz(0, 0, 0, -1);
        send_wxyz(1, 1, 1, 1);
        send_wxyz(11585, 11585, 0, 0);
        send_wxyz(8192, 8192, 8192, 8192);
        send_wxyz(-32768, 32767, -32768, 32767);
        send_wxyz(0, 0, 0, 0);
        send_wxyz(3, -5, 7, -2);
        send_wxyz(16383, -1, 2, 16384);
        send_wxyz(0, -32768, 0, 32767);
    endtask

    function automatic int rand_comp();
        case ($urandom_range(9))
            0: return $signed(16'($urandom_range(7))) - 4;
            1: return $urandom_range(1) ? 32767 : -32768;
            2: return 0;
            default: return $signed(16'($urandom()));
        endcase
    endfunction

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(49) == 0)
                send_wxyz(0, 0, 0, 0);
            else
                send_wxyz(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end
    endtask

    task automatic test_pause_until_empty();
        test_random(30);
        drain_results();
        test_random(30);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        err_cnt = 0; sent_cnt = 0; recv_cnt = 0; zero_cnt = 0; cyc = 0;
        send_idle_pct = 22;
        recv_idle_pct = 64;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(400);
        test_pause_until_empty();
        send_idle_pct = 64;
        recv_idle_pct = 22;
        test_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(400);
        drain_results();
        repeat (LATENCY + 10) @(posedge clk);
        $display("Sent %0d quaternions, checked %0d matrices (%0d zero inputs)",
                 sent_cnt, recv_cnt, zero_cnt);
        $display("Idle mixes covered: sender 22/receiver 64, swapped, none");
        if (err_cnt == 0 && pending_mats.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
